### hdl/dpa_pkg.sv
// shared types and constants for the data-processing alu
// opcode and condition encodings, decoded request and result records
// no dependencies
package dpa_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned OUT_DEPTH = 2;

    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_RSB = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_ADC = 4'd5;
    localparam logic [3:0] OP_SBC = 4'd6;
    localparam logic [3:0] OP_RSC = 4'd7;
    localparam logic [3:0] OP_TST = 4'd8;
    localparam logic [3:0] OP_TEQ = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_CMN = 4'd11;
    localparam logic [3:0] OP_ORR = 4'd12;
    localparam logic [3:0] OP_MOV = 4'd13;
    localparam logic [3:0] OP_BIC = 4'd14;
    localparam logic [3:0] OP_MVN = 4'd15;

    localparam logic [3:0] COND_EQ = 4'd0;
    localparam logic [3:0] COND_NE = 4'd1;
    localparam logic [3:0] COND_CS = 4'd2;
    localparam logic [3:0] COND_CC = 4'd3;
    localparam logic [3:0] COND_MI = 4'd4;
    localparam logic [3:0] COND_PL = 4'd5;
    localparam logic [3:0] COND_VS = 4'd6;
    localparam logic [3:0] COND_VC = 4'd7;
    localparam logic [3:0] COND_HI = 4'd8;
    localparam logic [3:0] COND_LS = 4'd9;
    localparam logic [3:0] COND_GE = 4'd10;
    localparam logic [3:0] COND_LT = 4'd11;
    localparam logic [3:0] COND_GT = 4'd12;
    localparam logic [3:0] COND_LE = 4'd13;
    localparam logic [3:0] COND_AL = 4'd14;
    localparam logic [3:0] COND_NV = 4'd15;

    localparam int unsigned FLAG_N = 3;
    localparam int unsigned FLAG_Z = 2;
    localparam int unsigned FLAG_C = 1;
    localparam int unsigned FLAG_V = 0;

    typedef enum logic [1:0] {
        CIN_ZERO,
        CIN_ONE,
        CIN_FLAG
    } cin_t;

    typedef enum logic [1:0] {
        LOG_AND,
        LOG_EOR,
        LOG_ORR,
        LOG_MOV
    } logic_op_t;

    typedef struct packed {
        logic [3:0]        cond;
        logic              compare;
        logic              arith;
        logic              upd;
        cin_t              cin_sel;
        logic_op_t         lop;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic              sh_c;
    } dec_t;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic              write_result;
        logic              executed;
        logic [3:0]        flags_out;
        logic              status;
    } res_t;

endpackage

### hdl/arm_data_processing_alu_top.sv
// top level of the data-processing alu: front decode, request queue, back end
// depends on dpa_pkg, dpa_front, dpa_queue, dpa_back
// a pushed request is registered in the request queue, then its result in the result queue of the back end
// throughput: one request per cycle while the result queue has room or is popped, set by the flag loop in the back end
// reset: queues empty, nzcv flags cleared; full and empty are valid right after reset
module arm_data_processing_alu_top
    import dpa_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [3:0]        condition,
    input  logic [3:0]        mode,
    input  logic              set_flags,
    input  logic [WORD_W-1:0] first_operand,
    input  logic [WORD_W-1:0] second_operand,
    input  logic              shifter_carry,
    output logic              empty,
    input  logic              pop,
    output logic [WORD_W-1:0] result,
    output logic              write_result,
    output logic              executed,
    output logic [3:0]        flags_out,
    output logic              status
);

    dec_t dec;
    dec_t q_data;
    logic q_empty;
    logic q_pop;

    dpa_front u_front (
        .condition      (condition),
        .mode           (mode),
        .set_flags      (set_flags),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .shifter_carry  (shifter_carry),
        .dec            (dec)
    );

    dpa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (dec),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    dpa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_data       (q_data),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .result       (result),
        .write_result (write_result),
        .executed     (executed),
        .flags_out    (flags_out),
        .status       (status)
    );

    a_back_takes_queued : assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("back end took a request from an empty queue");

    a_nv_not_executed : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status) |-> (!executed && !write_result))
        else $error("unpredictable condition reported as executed");

    a_write_needs_exec : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && write_result) |-> executed)
        else $error("write enable without execution");

    a_skipped_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !executed) |-> (result == '0))
        else $error("skipped request carries a nonzero result");

endmodule

### hdl/dpa_front.sv
// front end: classifies an opcode and prepares the adder and logic operands
// depends on dpa_pkg
module dpa_front
    import dpa_pkg::*;
(
    input  logic [3:0]        condition,
    input  logic [3:0]        mode,
    input  logic              set_flags,
    input  logic [WORD_W-1:0] first_operand,
    input  logic [WORD_W-1:0] second_operand,
    input  logic              shifter_carry,
    output dec_t              dec
);

    logic compare;

    assign compare = (mode == OP_TST) || (mode == OP_TEQ) ||
                     (mode == OP_CMP) || (mode == OP_CMN);

    always_comb
    begin
        dec.cond    = condition;
        dec.compare = compare;
        dec.upd     = compare || set_flags;
        dec.sh_c    = shifter_carry;
        dec.arith   = 1'b0;
        dec.cin_sel = CIN_ZERO;
        dec.lop     = LOG_AND;
        dec.x       = first_operand;
        dec.y       = second_operand;
        unique case (mode)
            OP_AND: dec.lop = LOG_AND;
            OP_EOR: dec.lop = LOG_EOR;
            OP_SUB:
            begin
                dec.arith   = 1'b1;
                dec.y       = ~second_operand;
                dec.cin_sel = CIN_ONE;
            end
            OP_RSB:
            begin
                dec.arith   = 1'b1;
                dec.x       = second_operand;
                dec.y       = ~first_operand;
                dec.cin_sel = CIN_ONE;
            end
            OP_ADD: dec.arith = 1'b1;
            OP_ADC:
            begin
                dec.arith   = 1'b1;
                dec.cin_sel = CIN_FLAG;
            end
            OP_SBC:
            begin
                dec.arith   = 1'b1;
                dec.y       = ~second_operand;
                dec.cin_sel = CIN_FLAG;
            end
            OP_RSC:
            begin
                dec.arith   = 1'b1;
                dec.x       = second_operand;
                dec.y       = ~first_operand;
                dec.cin_sel = CIN_FLAG;
            end
            OP_TST: dec.lop = LOG_AND;
            OP_TEQ: dec.lop = LOG_EOR;
            OP_CMP:
            begin
                dec.arith   = 1'b1;
                dec.y       = ~second_operand;
                dec.cin_sel = CIN_ONE;
            end
            OP_CMN: dec.arith = 1'b1;
            OP_ORR: dec.lop = LOG_ORR;
            OP_MOV: dec.lop = LOG_MOV;
            // bic and mvn use the inverted second operand
            OP_BIC:
            begin
                dec.lop = LOG_AND;
                dec.y   = ~second_operand;
            end
            OP_MVN:
            begin
                dec.lop = LOG_MOV;
                dec.y   = ~second_operand;
            end
        endcase
    end

endmodule

### hdl/dpa_queue.sv
// short queue of decoded requests between front and back end
// depends on dpa_pkg
module dpa_queue
    import dpa_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  dec_t wr_data,
    output logic full,
    input  logic rd_en,
    output dec_t rd_data,
    output logic empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    dec_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hdl/dpa_back.sv
// back end: condition check, adder and logic unit, nzcv flags, result queue
// depends on dpa_pkg
module dpa_back
    import dpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dec_t              q_data,
    input  logic              q_empty,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output logic [WORD_W-1:0] result,
    output logic              write_result,
    output logic              executed,
    output logic [3:0]        flags_out,
    output logic              status
);

    localparam int unsigned OPTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int unsigned OCNT_W = $clog2(OUT_DEPTH + 1);

    logic [3:0]        flags_reg;
    logic [3:0]        flags_next;
    res_t              out_mem [OUT_DEPTH];
    logic [OPTR_W-1:0] owr_ptr_reg;
    logic [OPTR_W-1:0] ord_ptr_reg;
    logic [OCNT_W-1:0] ocount_reg;
    logic [OPTR_W-1:0] owr_ptr_next;
    logic [OPTR_W-1:0] ord_ptr_next;
    logic [OCNT_W-1:0] ocount_next;
    logic              out_pop;
    logic              passes;
    logic              cin;
    logic [WORD_W:0]   sum;
    logic [WORD_W-1:0] logic_val;
    logic [WORD_W-1:0] r;
    logic [WORD_W-1:0] ovf_vec;
    logic [3:0]        nf;
    res_t              res;
    res_t              head;
    logic              fn;
    logic              fz;
    logic              fc;
    logic              fv;

    assign fn = flags_reg[FLAG_N];
    assign fz = flags_reg[FLAG_Z];
    assign fc = flags_reg[FLAG_C];
    assign fv = flags_reg[FLAG_V];

    always_comb
    begin
        unique case (q_data.cond)
            COND_EQ: passes = fz;
            COND_NE: passes = !fz;
            COND_CS: passes = fc;
            COND_CC: passes = !fc;
            COND_MI: passes = fn;
            COND_PL: passes = !fn;
            COND_VS: passes = fv;
            COND_VC: passes = !fv;
            COND_HI: passes = fc && !fz;
            COND_LS: passes = !fc || fz;
            COND_GE: passes = (fn == fv);
            COND_LT: passes = (fn != fv);
            COND_GT: passes = !fz && (fn == fv);
            COND_LE: passes = fz || (fn != fv);
            COND_AL: passes = 1'b1;
            COND_NV: passes = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (q_data.cin_sel)
            CIN_ZERO: cin = 1'b0;
            CIN_ONE:  cin = 1'b1;
            CIN_FLAG: cin = fc;
            default:  cin = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (q_data.lop)
            LOG_AND: logic_val = q_data.x & q_data.y;
            LOG_EOR: logic_val = q_data.x ^ q_data.y;
            LOG_ORR: logic_val = q_data.x | q_data.y;
            LOG_MOV: logic_val = q_data.y;
        endcase
    end

    assign sum     = {1'b0, q_data.x} + {1'b0, q_data.y} + {{WORD_W{1'b0}}, cin};
    assign r       = q_data.arith ? sum[WORD_W-1:0] : logic_val;
    assign ovf_vec = (q_data.x ^ r) & (q_data.y ^ r);

    always_comb
    begin
        nf[FLAG_N] = r[WORD_W-1];
        nf[FLAG_Z] = (r == '0);
        nf[FLAG_C] = q_data.arith ? sum[WORD_W] : q_data.sh_c;
        // logical operations keep overflow
        nf[FLAG_V] = q_data.arith ? ovf_vec[WORD_W-1] : fv;
    end

    assign flags_next = (passes && q_data.upd) ? nf : flags_reg;

    always_comb
    begin
        res.result       = (passes && !q_data.compare) ? r : '0;
        res.write_result = passes && !q_data.compare;
        res.executed     = passes;
        res.flags_out    = flags_next;
        res.status       = (q_data.cond == COND_NV);
    end

    assign empty   = (ocount_reg == '0);
    assign out_pop = pop && !empty;
    // take a request when the result queue has room or frees one this cycle
    assign q_pop   = !q_empty && ((ocount_reg != OCNT_W'(OUT_DEPTH)) || out_pop);

    always_comb
    begin
        owr_ptr_next = owr_ptr_reg;
        ord_ptr_next = ord_ptr_reg;
        ocount_next  = ocount_reg;
        if (q_pop)
        begin
            owr_ptr_next = (owr_ptr_reg == OPTR_W'(OUT_DEPTH - 1)) ? '0 : owr_ptr_reg + 1'b1;
        end
        if (out_pop)
        begin
            ord_ptr_next = (ord_ptr_reg == OPTR_W'(OUT_DEPTH - 1)) ? '0 : ord_ptr_reg + 1'b1;
        end
        if (q_pop && !out_pop)
        begin
            ocount_next = ocount_reg + 1'b1;
        end
        else if (out_pop && !q_pop)
        begin
            ocount_next = ocount_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg   <= '0;
            owr_ptr_reg <= '0;
            ord_ptr_reg <= '0;
            ocount_reg  <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                flags_reg <= flags_next;
            end
            owr_ptr_reg <= owr_ptr_next;
            ord_ptr_reg <= ord_ptr_next;
            ocount_reg  <= ocount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_mem[owr_ptr_reg] <= res;
        end
    end

    assign head         = out_mem[ord_ptr_reg];
    assign result       = head.result;
    assign write_result = head.write_result;
    assign executed     = head.executed;
    assign flags_out    = head.flags_out;
    assign status       = head.status;

endmodule

### bench/dpa_result_checker.sv
`timescale 1ns / 1ps
// result checker for the data-processing alu: predicts each accepted request
// and compares the popped results in order; depends on dpa_pkg
module dpa_result_checker
    import dpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  logic [3:0]        condition,
    input  logic [3:0]        mode,
    input  logic              set_flags,
    input  logic [WORD_W-1:0] first_operand,
    input  logic [WORD_W-1:0] second_operand,
    input  logic              shifter_carry,
    input  logic              empty,
    input  logic              pop,
    input  logic [WORD_W-1:0] result,
    input  logic              write_result,
    input  logic              executed,
    input  logic [3:0]        flags_out,
    input  logic              status,
    output int                pending,
    output int                fails
);

    res_t expected_results[$];
    res_t want;
    logic [3:0] flags_now;
    int fail_cnt;

    function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] f);
        logic n;
        logic z;
        logic c;
        logic v;
        logic pass;
        n = f[FLAG_N];
        z = f[FLAG_Z];
        c = f[FLAG_C];
        v = f[FLAG_V];
        case (cond)
            COND_EQ: pass = z;
            COND_NE: pass = !z;
            COND_CS: pass = c;
            COND_CC: pass = !c;
            COND_MI: pass = n;
            COND_PL: pass = !n;
            COND_VS: pass = v;
            COND_VC: pass = !v;
            COND_HI: pass = c && !z;
            COND_LS: pass = !c || z;
            COND_GE: pass = (n == v);
            COND_LT: pass = (n != v);
            COND_GT: pass = !z && (n == v);
            COND_LE: pass = z || (n != v);
            COND_AL: pass = 1'b1;
            default: pass = 1'b0;
        endcase
        return pass;
    endfunction

    // returns {carry, overflow, sum}
    function automatic logic [33:0] add_word(input logic [31:0] a, input logic [31:0] b,
                                             input logic cin);
        logic [32:0] wide;
        logic        ovf;
        wide = {1'b0, a} + {1'b0, b} + {32'd0, cin};
        ovf = (a[31] == b[31]) && (wide[31] != a[31]);
        return {wide[32], ovf, wide[31:0]};
    endfunction

    function automatic res_t predict_alu(input logic [3:0] cond, input logic [3:0] op,
                                         input logic s, input logic [31:0] a,
                                         input logic [31:0] b, input logic shc,
                                         input logic [3:0] f);
        res_t        r;
        logic [31:0] val;
        logic [3:0]  nf;
        logic        c;
        logic        v;
        logic        arith;
        logic        cmp;
        logic        cf;
        r = '0;
        r.flags_out = f;
        c = 1'b0;
        v = 1'b0;
        cf = f[FLAG_C];
        arith = 1'b1;
        cmp = (op == OP_TST) || (op == OP_TEQ) || (op == OP_CMP) || (op == OP_CMN);
        if (cond == COND_NV) begin
            r.status = 1'b1;
        end
        else if (cond_holds(cond, f)) begin
            case (op)
                OP_SUB, OP_CMP: {c, v, val} = add_word(a, ~b, 1'b1);
                OP_RSB:         {c, v, val} = add_word(b, ~a, 1'b1);
                OP_ADD, OP_CMN: {c, v, val} = add_word(a, b, 1'b0);
                OP_ADC:         {c, v, val} = add_word(a, b, cf);
                OP_SBC:         {c, v, val} = add_word(a, ~b, cf);
                OP_RSC:         {c, v, val} = add_word(b, ~a, cf);
                default:        arith = 1'b0;
            endcase
            case (op)
                OP_AND, OP_TST: val = a & b;
                OP_EOR, OP_TEQ: val = a ^ b;
                OP_ORR:         val = a | b;
                OP_MOV:         val = b;
                OP_BIC:         val = a & ~b;
                OP_MVN:         val = ~b;
                default:        ;
            endcase
            if (cmp || s) begin
                nf[FLAG_N] = val[31];
                nf[FLAG_Z] = (val == 32'd0);
                nf[FLAG_C] = arith ? c : shc;
                nf[FLAG_V] = arith ? v : f[FLAG_V];
                r.flags_out = nf;
            end
            r.result = cmp ? 32'd0 : val;
            r.write_result = !cmp;
            r.executed = 1'b1;
        end
        return r;
    endfunction

    task automatic check_field(input string label, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_now = '0;
            expected_results.delete();
            fail_cnt = 0;
            pending <= 0;
            fails <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result popped with no request waiting, got result %0h",
                             $time, result);
                    fail_cnt++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("result", want.result, result);
                    check_field("write_result", {31'd0, want.write_result},
                                {31'd0, write_result});
                    check_field("executed", {31'd0, want.executed}, {31'd0, executed});
                    check_field("flags_out", {28'd0, want.flags_out}, {28'd0, flags_out});
                    check_field("status", {31'd0, want.status}, {31'd0, status});
                end
            end
            if (push && !full)
            begin
                want = predict_alu(condition, mode, set_flags, first_operand,
                                   second_operand, shifter_carry, flags_now);
                flags_now = want.flags_out;
                expected_results.push_back(want);
            end
            pending <= expected_results.size();
            fails <= fail_cnt;
        end
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// testbench top for arm_data_processing_alu_top: clock, reset, request and pop traffic
// depends on dpa_pkg, the alu top level and dpa_result_checker
module tb_top;
    import dpa_pkg::*;

    localparam int RANDOM_ITEMS   = 1430;
    localparam int QUIET_TAIL     = 150;
    localparam int HOLD_AT        = 400;
    localparam int LONG_HOLD      = 80;
    localparam int TAIL_CYCLES    = 12;
    localparam int WATCHDOG_LIMIT = 2000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push;
    logic              full;
    logic [3:0]        condition;
    logic [3:0]        mode;
    logic              set_flags;
    logic [WORD_W-1:0] first_operand;
    logic [WORD_W-1:0] second_operand;
    logic              shifter_carry;
    logic              empty;
    logic              pop;
    logic [WORD_W-1:0] result;
    logic              write_result;
    logic              executed;
    logic [3:0]        flags_out;
    logic              status;

    int pending;
    int fails;
    int stall_cycles = 0;
    bit idle_on = 1'b1;
    bit hold_request = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    arm_data_processing_alu_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .condition      (condition),
        .mode           (mode),
        .set_flags      (set_flags),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .shifter_carry  (shifter_carry),
        .empty          (empty),
        .pop            (pop),
        .result         (result),
        .write_result   (write_result),
        .executed       (executed),
        .flags_out      (flags_out),
        .status         (status)
    );

    dpa_result_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .condition      (condition),
        .mode           (mode),
        .set_flags      (set_flags),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .shifter_carry  (shifter_carry),
        .empty          (empty),
        .pop            (pop),
        .result         (result),
        .write_result   (write_result),
        .executed       (executed),
        .flags_out      (flags_out),
        .status         (status),
        .pending        (pending),
        .fails          (fails)
    );

    // operand values lean toward the carry and overflow corners
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        case ($urandom_range(0, 7))
            0:       w = 32'h0000_0000;
            1:       w = 32'hffff_ffff;
            2:       w = 32'h8000_0000;
            3:       w = 32'h7fff_ffff;
            4:       w = 32'h0000_0001;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic send_req(input logic [3:0] cond, input logic [3:0] op, input logic s,
                            input logic [31:0] a, input logic [31:0] b, input logic shc);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        push <= 1'b1;
        condition <= cond;
        mode <= op;
        set_flags <= s;
        first_operand <= a;
        second_operand <= b;
        shifter_carry <= shc;
        do
            @(posedge clk);
        while (full);
    endtask

    initial
    begin
        logic [3:0] op;
        logic [3:0] cond;
        push <= 1'b0;
        condition <= COND_AL;
        mode <= OP_AND;
        set_flags <= 1'b0;
        first_operand <= '0;
        second_operand <= '0;
        shifter_carry <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // flags start cleared
        send_req(COND_AL, OP_MOV, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1);
        send_req(COND_EQ, OP_ADD, 1'b1, 32'hffff_ffff, 32'h0000_0001, 1'b0);
        send_req(COND_AL, OP_ADD, 1'b1, 32'h7fff_ffff, 32'h0000_0001, 1'b0);
        send_req(COND_VS, OP_SUB, 1'b1, 32'h0000_0000, 32'h0000_0001, 1'b1);
        // s clear keeps flags
        send_req(COND_AL, OP_SUB, 1'b0, 32'h0000_0005, 32'h0000_0003, 1'b0);
        // failing condition, then the unpredictable code
        send_req(COND_PL, OP_MOV, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        send_req(COND_NV, OP_MOV, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        // compare updates flags with s clear
        send_req(COND_AL, OP_CMP, 1'b0, 32'h0000_0001, 32'h0000_0001, 1'b0);
        send_req(COND_CS, OP_ADC, 1'b1, 32'hffff_ffff, 32'h0000_0000, 1'b0);
        for (int i = 0; i < 16; i++)
        begin
            op = i[3:0];
            send_req(COND_AL, op, 1'b1, op[0] ? 32'h8000_0000 : 32'hffff_ffff,
                     op[1] ? 32'h8000_0000 : 32'h0000_0001, op[2]);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - QUIET_TAIL)
                idle_on = 1'b0;
            if (i == HOLD_AT)
                hold_request = 1'b1;
            cond = ($urandom_range(0, 2) == 0) ? COND_AL : 4'($urandom_range(0, 15));
            send_req(cond, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                     pick_word(), pick_word(), 1'($urandom_range(0, 1)));
        end
        push <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0t: %0d failures, %0d results never arrived", $time, fails, pending);
            $display("TEST FAILED");
        end
        $finish;
    end

    // result side: random pop bursts, plus one long hold so the queue backs up
    initial
    begin
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no request or result moved for %0d cycles", $time, stall_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule

### filelist.f
hdl/dpa_pkg.sv
hdl/dpa_front.sv
hdl/dpa_queue.sv
hdl/dpa_back.sv
hdl/arm_data_processing_alu_top.sv
bench/dpa_result_checker.sv
bench/tb_top.sv
